// ===== src/stc_pkg.sv =====
// Shared types, constants and helpers for the string token classifier.
package stc_pkg;

   // Widths of the item fields and registers
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned KIND_W   = 3;
   localparam int unsigned LEN_W    = 33;
   localparam int unsigned LIMIT_W  = 16;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned RSP_DATA_W = 40;

   // Token kinds reported on the result channel
   localparam logic [KIND_W-1:0] KIND_ERROR    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ATOM     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_QUOTED   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_LIT_SYNC = 3'd3;
   localparam logic [KIND_W-1:0] KIND_LIT_NONSYNC = 3'd4;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ATOM_LIMIT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUOTED_LIMIT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LITERAL_LIMIT = 2'd2;

   // Register reset values and literal cap
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd1024;
   localparam logic [LEN_W-1:0]   LITERAL_CAP = 33'h1_0000_0000;
   localparam logic [LEN_W-1:0]   VALUE_MAX   = 33'h1_FFFF_FFFF;

   // Character codes
   localparam logic [BYTE_W-1:0] CH_DQUOTE    = 8'h22;
   localparam logic [BYTE_W-1:0] CH_PLUS      = 8'h2B;
   localparam logic [BYTE_W-1:0] CH_ZERO      = 8'h30;
   localparam logic [BYTE_W-1:0] CH_NINE      = 8'h39;
   localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
   localparam logic [BYTE_W-1:0] CH_LBRACE    = 8'h7B;
   localparam logic [BYTE_W-1:0] CH_RBRACE    = 8'h7D;

   typedef logic [BYTE_W-1:0] byte_type;

   // Atom characters: printable ASCII minus specials
   function automatic logic is_atom_byte(input byte_type b);
      return (b == 8'h21) || (b >= 8'h23 && b <= 8'h27) ||
             (b >= 8'h2A && b <= 8'h5B) || (b >= 8'h5D && b <= 8'h7A) ||
             (b >= 8'h7C && b <= 8'h7E);
   endfunction

endpackage

// ===== src/string_token_classifier.sv =====
// Top level: per-byte token classifier with input and result registers.
//
// Takes one token byte per item on req_ and returns one result item on rsp_
// for each byte marked req_tlast: the token kind on rsp_tuser and the content
// length on rsp_tdata (0 on error). One item is accepted every clock cycle
// while input is not stalled. The result of a final byte is classified from
// the input register and loaded into the result register, from which it is
// offered on rsp_. A pending result only stalls input when the next final
// byte reaches the classify stage while the result register is still full
// and rsp_tready is low. The user must write limits through csr_ only while
// the block is idle; the block itself does not enforce this. COUNT_WIDTH
// sets the byte counter width. Tokens longer than 2**COUNT_WIDTH-1 bytes
// are never atoms or quoted strings.
module string_token_classifier #(
   parameter int unsigned COUNT_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   // input item channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] token_byte
   input  logic        req_tlast,   // final_byte
   input  logic        req_tuser,   // [0] line_end
   // result item channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [stc_pkg::RSP_DATA_W-1:0] rsp_tdata,  // [32:0] content_length, rest zero
   output logic [stc_pkg::KIND_W-1:0]     rsp_tuser,  // [2:0] token_kind
   // configuration writes
   input  logic        csr_we,
   input  logic [stc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [stc_pkg::LEN_W-1:0]     csr_wdata
);

   localparam int unsigned LEN_W = stc_pkg::LEN_W;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   typedef enum logic [2:0] {
      QP_START, QP_BODY, QP_ESC, QP_CONT, QP_DEAD
   } quote_phase_type;

   typedef enum logic [2:0] {
      LP_START, LP_BRACE, LP_DIGITS, LP_PLUS, LP_DEAD
   } literal_phase_type;

   // configuration registers
   logic [stc_pkg::LIMIT_W-1:0] atom_limit_ff, quoted_limit_ff;
   logic [LEN_W-1:0]            literal_limit_ff;

   // input register
   logic                 in_valid_ff;
   stc_pkg::byte_type    in_byte_ff;
   logic                 in_last_ff, in_eol_ff;

   // token state
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   over_ff, over_in;
   logic                   atom_ok_ff, atom_ok_in;
   quote_phase_type        qphase_ff, qphase_in;
   logic [1:0]             cont_left_ff, cont_left_in;
   literal_phase_type      lphase_ff, lphase_in;
   logic [LEN_W-1:0]       lit_value_ff, lit_value_in;

   // result register
   logic                      out_valid_ff;
   logic [stc_pkg::KIND_W-1:0] out_kind_ff, out_kind_in;
   logic [LEN_W-1:0]          out_len_ff, out_len_in;

   // handshake
   logic out_free, proc, load_out;
   logic is_digit;
   logic [3:0] digit_val;
   logic [LEN_W+3:0] times_ten;
   logic [LEN_W-1:0] lim_eff, count_ext;

   assign out_free   = ~out_valid_ff | rsp_tready;
   assign proc       = in_valid_ff & (~in_last_ff | out_free);
   assign load_out   = proc & in_last_ff;
   assign req_tready = ~in_valid_ff | proc;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tdata  = {{(stc_pkg::RSP_DATA_W-LEN_W){1'b0}}, out_len_ff};

   // digit decode and value times ten plus digit
   assign is_digit  = (in_byte_ff >= stc_pkg::CH_ZERO) && (in_byte_ff <= stc_pkg::CH_NINE);
   assign digit_val = 4'(in_byte_ff - stc_pkg::CH_ZERO);
   assign times_ten = {1'b0, lit_value_ff, 3'b000} + {3'b000, lit_value_ff, 1'b0}
                      + {{LEN_W{1'b0}}, digit_val};

   assign lim_eff   = (literal_limit_ff > stc_pkg::LITERAL_CAP) ?
                      stc_pkg::LITERAL_CAP : literal_limit_ff;
   assign count_ext = {{(LEN_W-COUNT_WIDTH){1'b0}}, count_in};

   // next token state and classification
   always_comb begin
      count_in     = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;
      over_in      = over_ff | (count_ff == COUNT_MAX);
      atom_ok_in   = atom_ok_ff & stc_pkg::is_atom_byte(in_byte_ff);
      qphase_in    = qphase_ff;
      cont_left_in = cont_left_ff;
      lphase_in    = lphase_ff;
      lit_value_in = lit_value_ff;
      out_kind_in  = stc_pkg::KIND_ERROR;
      out_len_in   = '0;

      // quoted string checker
      case (qphase_ff)
         QP_START: begin
            qphase_in = (in_byte_ff == stc_pkg::CH_DQUOTE) ? QP_BODY : QP_DEAD;
         end
         QP_BODY: begin
            if (in_byte_ff == stc_pkg::CH_BACKSLASH) begin
               qphase_in = QP_ESC;
            end else if (in_byte_ff >= 8'h01 && in_byte_ff <= 8'h7F &&
                         in_byte_ff != stc_pkg::CH_DQUOTE) begin
               qphase_in = QP_BODY;
            end else if (in_byte_ff >= 8'hC0 && in_byte_ff <= 8'hDF) begin
               cont_left_in = 2'd1;
               qphase_in    = QP_CONT;
            end else if (in_byte_ff >= 8'hE0 && in_byte_ff <= 8'hEF) begin
               cont_left_in = 2'd2;
               qphase_in    = QP_CONT;
            end else if (in_byte_ff >= 8'hF0 && in_byte_ff <= 8'hF7) begin
               cont_left_in = 2'd3;
               qphase_in    = QP_CONT;
            end else begin
               qphase_in = QP_DEAD;
            end
         end
         QP_ESC: begin
            qphase_in = (in_byte_ff == stc_pkg::CH_DQUOTE ||
                         in_byte_ff == stc_pkg::CH_BACKSLASH) ? QP_BODY : QP_DEAD;
         end
         QP_CONT: begin
            if (in_byte_ff >= 8'h80 && in_byte_ff <= 8'hBF && cont_left_ff != 2'd0) begin
               cont_left_in = cont_left_ff - 2'd1;
               if (cont_left_ff == 2'd1) begin
                  qphase_in = QP_BODY;
               end
            end else begin
               cont_left_in = 2'd0;
               qphase_in    = QP_DEAD;
            end
         end
         default: begin
            qphase_in = QP_DEAD;
         end
      endcase

      // literal announcement checker
      case (lphase_ff)
         LP_START: begin
            lphase_in = (in_byte_ff == stc_pkg::CH_LBRACE) ? LP_BRACE : LP_DEAD;
         end
         LP_BRACE: begin
            if (is_digit) begin
               lit_value_in = {{(LEN_W-4){1'b0}}, digit_val};
               lphase_in    = LP_DIGITS;
            end else begin
               lphase_in = LP_DEAD;
            end
         end
         LP_DIGITS: begin
            if (is_digit) begin
               lit_value_in = (times_ten[LEN_W+3:LEN_W] != 4'd0) ?
                              stc_pkg::VALUE_MAX : times_ten[LEN_W-1:0];
            end else if (in_byte_ff == stc_pkg::CH_PLUS) begin
               lphase_in = LP_PLUS;
            end else begin
               lphase_in = LP_DEAD;
            end
         end
         default: begin
            lphase_in = LP_DEAD;
         end
      endcase

      // classify on the final byte
      if (in_byte_ff == stc_pkg::CH_RBRACE && (lphase_ff == LP_DIGITS || lphase_ff == LP_PLUS)) begin
         if (in_eol_ff && lit_value_ff <= lim_eff) begin
            out_kind_in = (lphase_ff == LP_PLUS) ? stc_pkg::KIND_LIT_NONSYNC
                                                 : stc_pkg::KIND_LIT_SYNC;
            out_len_in  = lit_value_ff;
         end
      end else if (atom_ok_in && !over_in &&
                   count_ext <= {{(LEN_W-stc_pkg::LIMIT_W){1'b0}}, atom_limit_ff}) begin
         out_kind_in = stc_pkg::KIND_ATOM;
         out_len_in  = count_ext;
      end else if (qphase_ff == QP_BODY && in_byte_ff == stc_pkg::CH_DQUOTE && !over_in &&
                   count_ext >= 33'd2 &&
                   count_ext <= {{(LEN_W-stc_pkg::LIMIT_W){1'b0}}, quoted_limit_ff}) begin
         out_kind_in = stc_pkg::KIND_QUOTED;
         out_len_in  = count_ext - 33'd2;
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         atom_limit_ff    <= stc_pkg::LIMIT_RESET;
         quoted_limit_ff  <= stc_pkg::LIMIT_RESET;
         literal_limit_ff <= stc_pkg::LITERAL_CAP;
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         count_ff         <= '0;
         over_ff          <= 1'b0;
         atom_ok_ff       <= 1'b1;
         qphase_ff        <= QP_START;
         cont_left_ff     <= 2'd0;
         lphase_ff        <= LP_START;
         lit_value_ff     <= '0;
      end else begin
         // configuration writes
         if (csr_we) begin
            case (csr_index)
               stc_pkg::CSR_ATOM_LIMIT:    atom_limit_ff    <= csr_wdata[stc_pkg::LIMIT_W-1:0];
               stc_pkg::CSR_QUOTED_LIMIT:  quoted_limit_ff  <= csr_wdata[stc_pkg::LIMIT_W-1:0];
               stc_pkg::CSR_LITERAL_LIMIT: literal_limit_ff <= csr_wdata;
               default: ;
            endcase
         end

         // input register
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end

         // token state: advance on ordinary bytes, clear after the final one
         if (proc) begin
            if (in_last_ff) begin
               count_ff     <= '0;
               over_ff      <= 1'b0;
               atom_ok_ff   <= 1'b1;
               qphase_ff    <= QP_START;
               cont_left_ff <= 2'd0;
               lphase_ff    <= LP_START;
               lit_value_ff <= '0;
            end else begin
               count_ff     <= count_in;
               over_ff      <= over_in;
               atom_ok_ff   <= atom_ok_in;
               qphase_ff    <= qphase_in;
               cont_left_ff <= cont_left_in;
               lphase_ff    <= lphase_in;
               lit_value_ff <= lit_value_in;
            end
         end

         // result register
         if (load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
         in_eol_ff  <= req_tuser;
      end
      if (load_out) begin
         out_kind_ff <= out_kind_in;
         out_len_ff  <= out_len_in;
      end
   end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for string_token_classifier: directed token table, then random tokens.
module tb;
   import stc_pkg::*;

   localparam int unsigned CNT_W       = 16;
   localparam int unsigned PIPE_LAT    = 8;     // generous over the two-stage result path
   localparam int unsigned STALL_LIMIT = 2000;  // cycles with no item moving on either side
   localparam int unsigned PHASE_BYTES = 170;
   localparam int unsigned NUM_PHASES  = 8;
   localparam int unsigned MAX_PRINTS  = 40;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic [CNT_W-1:0]     CNT_MAX    = '1;
   localparam bit TYPED   = 1'b1;
   localparam bit PREDICT = 1'b0;

   typedef enum logic [2:0] {Q_START, Q_BODY, Q_ESC, Q_CONT, Q_DEAD} quote_state_type;
   typedef enum logic [2:0] {L_START, L_BRACE, L_DIGITS, L_PLUS, L_DEAD} lit_state_type;
   typedef enum int {F_ATOM, F_QUOTED, F_LITERAL, F_NOISE, F_BROKEN} tok_form_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [LEN_W-1:0]  len;
   } token_result_type;

   typedef struct {
      int                n;
      logic [127:0]      bytes;   // first byte in the highest used byte lane
      bit                eol;
      bit                typed;
      token_result_type  res;
   } token_row_type;

   // DUT signals
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = '0;
   logic                  req_tlast = 1'b0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [KIND_W-1:0]     rsp_tuser;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [LEN_W-1:0]      csr_wdata = '0;

   // Predictor copy of the limits and the per-token state
   logic [LIMIT_W-1:0] lim_atom   = LIMIT_RESET;
   logic [LIMIT_W-1:0] lim_quoted = LIMIT_RESET;
   logic [LEN_W-1:0]   lim_lit    = LITERAL_CAP;
   logic [CNT_W-1:0]   tok_count;
   bit                 tok_over;
   bit                 atom_ok;
   quote_state_type    qstate;
   logic [1:0]         cont_due;
   lit_state_type      lstate;
   logic [LEN_W-1:0]   lit_val;

   token_result_type results_due[$];
   token_row_type    token_rows[$];
   logic [7:0]       tok_bytes[$];
   int               snd_pct = 0;
   int               rcv_pct = 0;
   int               errors = 0;
   int               quiet_cycles = 0;

   string_token_classifier #(.COUNT_WIDTH(CNT_W)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [7:0] token_byte
      .req_tlast  (req_tlast),    // final_byte
      .req_tuser  (req_tuser),    // [0] line_end
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [32:0] content_length, rest zero
      .rsp_tuser  (rsp_tuser),    // [2:0] token_kind
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Printable ASCII except the protocol specials
   function automatic bit is_atom_char(input logic [7:0] b);
      return b >= 8'h21 && b <= 8'h7E && b != 8'h22 && b != 8'h28 && b != 8'h29 &&
             b != 8'h5C && b != 8'h7B;
   endfunction

   function automatic void clear_token_state();
      tok_count = '0;
      tok_over  = 1'b0;
      atom_ok   = 1'b1;
      qstate    = Q_START;
      cont_due  = '0;
      lstate    = L_START;
      lit_val   = '0;
   endfunction

   // Advance the checkers by one byte (quoted and literal only before the last); on the final byte classify the token
   function automatic bit classify_byte(input logic [7:0] b, input bit last, input bit eol,
                                        output token_result_type res);
      logic [LEN_W+3:0] acc;
      logic [LEN_W-1:0] cap;
      bit               digit;
      res = '{kind: KIND_ERROR, len: '0};
      if (tok_count == CNT_MAX) tok_over = 1'b1;
      else tok_count = tok_count + 1'b1;
      if (!is_atom_char(b)) atom_ok = 1'b0;
      digit = (b >= CH_ZERO && b <= CH_NINE);

      if (!last) begin
         // quoted string checker
         case (qstate)
            Q_START: qstate = (b == CH_DQUOTE) ? Q_BODY : Q_DEAD;
            Q_BODY: begin
               if (b == CH_BACKSLASH) qstate = Q_ESC;
               else if (b >= 8'h01 && b <= 8'h7F && b != CH_DQUOTE) qstate = Q_BODY;
               else if (b >= 8'hC0 && b <= 8'hDF) begin
                  cont_due = 2'd1;
                  qstate   = Q_CONT;
               end else if (b >= 8'hE0 && b <= 8'hEF) begin
                  cont_due = 2'd2;
                  qstate   = Q_CONT;
               end else if (b >= 8'hF0 && b <= 8'hF7) begin
                  cont_due = 2'd3;
                  qstate   = Q_CONT;
               end else qstate = Q_DEAD;
            end
            Q_ESC: qstate = (b == CH_DQUOTE || b == CH_BACKSLASH) ? Q_BODY : Q_DEAD;
            Q_CONT: begin
               if (b >= 8'h80 && b <= 8'hBF && cont_due != 0) begin
                  cont_due = cont_due - 1'b1;
                  if (cont_due == 0) qstate = Q_BODY;
               end else begin
                  cont_due = '0;
                  qstate   = Q_DEAD;
               end
            end
            default: qstate = Q_DEAD;
         endcase
         // literal announcement checker
         case (lstate)
            L_START: lstate = (b == CH_LBRACE) ? L_BRACE : L_DEAD;
            L_BRACE: begin
               if (digit) begin
                  lit_val = {25'b0, b - CH_ZERO};
                  lstate  = L_DIGITS;
               end else lstate = L_DEAD;
            end
            L_DIGITS: begin
               if (digit) begin
                  acc = {4'b0, lit_val} * 37'd10 + {29'b0, b - CH_ZERO};
                  lit_val = (acc > {4'b0, VALUE_MAX}) ? VALUE_MAX : acc[LEN_W-1:0];
               end else if (b == CH_PLUS) lstate = L_PLUS;
               else lstate = L_DEAD;
            end
            default: lstate = L_DEAD;
         endcase
         return 1'b0;
      end

      // final byte: literal first, then atom, then quoted string
      if (b == CH_RBRACE && (lstate == L_DIGITS || lstate == L_PLUS)) begin
         cap = (lim_lit > LITERAL_CAP) ? LITERAL_CAP : lim_lit;
         if (eol && lit_val <= cap) begin
            res.kind = (lstate == L_PLUS) ? KIND_LIT_NONSYNC : KIND_LIT_SYNC;
            res.len  = lit_val;
         end
      end else if (atom_ok && !tok_over && tok_count <= lim_atom) begin
         res.kind = KIND_ATOM;
         res.len  = LEN_W'(tok_count);
      end else if (qstate == Q_BODY && b == CH_DQUOTE && !tok_over && tok_count >= 2 &&
                   tok_count <= lim_quoted) begin
         res.kind = KIND_QUOTED;
         res.len  = LEN_W'(tok_count) - LEN_W'(2);
      end
      clear_token_state();
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      if (errors < MAX_PRINTS)
         $display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, want, got);
      errors++;
   endtask

   // Drive one item, with a random idle gap in front of it
   task automatic send_item(input logic [7:0] b, input bit last, input bit eol,
                            input bit typed, input token_result_type typed_res);
      token_result_type res;
      int               gap;
      gap = 0;
      while ($urandom_range(0, 99) < snd_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      req_tuser  <= eol;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (classify_byte(b, last, eol, res)) results_due.push_back(typed ? typed_res : res);
   endtask

   // Send tok_bytes as one token; line_end is random on the bytes before the last
   task automatic send_token(input bit eol, input bit typed, input token_result_type typed_res);
      int n;
      n = tok_bytes.size();
      for (int i = 0; i < n; i++)
         send_item(tok_bytes[i], i == n - 1, (i == n - 1) ? eol : bit'($urandom_range(0, 1)),
                   typed, typed_res);
   endtask

   // Stop sending and let every pending result drain
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (PIPE_LAT) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_ATOM_LIMIT:    lim_atom   = val[LIMIT_W-1:0];
         CSR_QUOTED_LIMIT:  lim_quoted = val[LIMIT_W-1:0];
         CSR_LITERAL_LIMIT: lim_lit    = val;
         default: ;
      endcase
   endtask

   task automatic set_limits(input logic [LIMIT_W-1:0] atom, input logic [LIMIT_W-1:0] quoted,
                             input logic [LEN_W-1:0] lit, input bit poke_unused);
      wait_idle();
      write_csr(CSR_ATOM_LIMIT, {17'b0, atom});
      write_csr(CSR_QUOTED_LIMIT, {17'b0, quoted});
      write_csr(CSR_LITERAL_LIMIT, lit);
      // a write to the spare index must leave every limit alone
      if (poke_unused) write_csr(CSR_UNUSED, VALUE_MAX);
      csr_we <= 1'b0;
   endtask

   task automatic add_row(input int n, input logic [127:0] bytes, input bit eol, input bit typed,
                          input logic [KIND_W-1:0] kind, input logic [LEN_W-1:0] len);
      token_row_type row;
      row.n     = n;
      row.bytes = bytes;
      row.eol   = eol;
      row.typed = typed;
      row.res   = '{kind: kind, len: len};
      token_rows.push_back(row);
   endtask

   function automatic logic [7:0] rand_atom_char();
      logic [7:0] b;
      do b = 8'($urandom_range(8'h21, 8'h7E)); while (!is_atom_char(b));
      return b;
   endfunction

   // Mostly well-formed tokens with random content, some noise and some damaged ones
   task automatic build_random_token(output bit eol);
      tok_form_type form, base;
      int           pick, n, k, pos;
      logic [7:0]   b;
      tok_bytes.delete();
      pick = $urandom_range(0, 99);
      form = (pick < 25) ? F_ATOM : (pick < 55) ? F_QUOTED : (pick < 80) ? F_LITERAL :
             (pick < 90) ? F_NOISE : F_BROKEN;
      base = (form == F_BROKEN) ? tok_form_type'($urandom_range(0, 2)) : form;
      eol  = $urandom_range(0, 1);
      case (base)
         F_ATOM: begin
            n = $urandom_range(1, 10);
            if ($urandom_range(0, 7) == 0) n = $urandom_range(1, 40);
            repeat (n) tok_bytes.push_back(rand_atom_char());
         end
         F_QUOTED: begin
            tok_bytes.push_back(CH_DQUOTE);
            n = $urandom_range(0, 8);
            repeat (n) begin
               case ($urandom_range(0, 4))
                  0, 1: begin
                     do b = 8'($urandom_range(1, 8'h7F));
                     while (b == CH_DQUOTE || b == CH_BACKSLASH);
                     tok_bytes.push_back(b);
                  end
                  2: begin
                     tok_bytes.push_back(CH_BACKSLASH);
                     tok_bytes.push_back($urandom_range(0, 1) ? CH_DQUOTE : CH_BACKSLASH);
                  end
                  default: begin
                     // UTF-8 sequence of 2 to 4 bytes
                     k = $urandom_range(1, 3);
                     case (k)
                        1:       tok_bytes.push_back(8'($urandom_range(8'hC0, 8'hDF)));
                        2:       tok_bytes.push_back(8'($urandom_range(8'hE0, 8'hEF)));
                        default: tok_bytes.push_back(8'($urandom_range(8'hF0, 8'hF7)));
                     endcase
                     repeat (k) tok_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
                  end
               endcase
            end
            tok_bytes.push_back(CH_DQUOTE);
         end
         F_LITERAL: begin
            tok_bytes.push_back(CH_LBRACE);
            n = $urandom_range(1, 4);
            if ($urandom_range(0, 5) == 0) n = $urandom_range(5, 12);
            repeat (n) tok_bytes.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
            if ($urandom_range(0, 2) == 0) tok_bytes.push_back(CH_PLUS);
            tok_bytes.push_back(CH_RBRACE);
            eol = ($urandom_range(0, 9) != 0);
         end
         default: begin
            n = $urandom_range(1, 8);
            repeat (n) tok_bytes.push_back(8'($urandom_range(0, 255)));
         end
      endcase
      // damage one spot: overwrite, drop or insert a byte
      if (form == F_BROKEN) begin
         pos = $urandom_range(0, tok_bytes.size() - 1);
         case ($urandom_range(0, 2))
            0: tok_bytes[pos] = 8'($urandom_range(0, 255));
            1: if (tok_bytes.size() > 1) tok_bytes.delete(pos);
            default: tok_bytes.insert(pos, 8'($urandom_range(0, 255)));
         endcase
      end
   endtask

   // Result checker and receiver back-pressure
   always @(posedge clock) begin
      token_result_type due;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (results_due.size() == 0) begin
               report_mismatch("result with none due", '0, {rsp_tuser, rsp_tdata});
            end else begin
               due = results_due.pop_front();
               if (rsp_tuser !== due.kind) report_mismatch("token_kind", due.kind, rsp_tuser);
               if (rsp_tdata !== {7'b0, due.len})
                  report_mismatch("content_length", due.len, rsp_tdata);
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= rcv_pct);
      end
   end

   // Watchdog: ends the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      token_row_type row;
      bit            eol;
      int            phase_bytes;
      logic [LEN_W-1:0] lit;
      clear_token_state();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed tokens under the reset limits
      add_row(1, 128'h61, 0, TYPED, KIND_ATOM, 33'd1);
      add_row(2, 128'h217E, 0, TYPED, KIND_ATOM, 33'd2);
      add_row(2, 128'h2222, 0, TYPED, KIND_QUOTED, 33'd0);
      add_row(3, 128'h7B307D, 1, TYPED, KIND_LIT_SYNC, 33'd0);
      add_row(12, 128'h7B343239343936373239367D, 1, TYPED, KIND_LIT_SYNC, LITERAL_CAP);
      add_row(13, 128'h7B34323934393637323937_2B7D, 1, TYPED, KIND_ERROR, 33'd0);
      add_row(13, 128'h7B3939393939393939393939_7D, 1, TYPED, KIND_ERROR, 33'd0);
      add_row(5, 128'h7B31322B7D, 1, TYPED, KIND_LIT_NONSYNC, 33'd12);
      add_row(3, 128'h7B357D, 0, TYPED, KIND_ERROR, 33'd0);       // literal mid-line
      add_row(2, 128'h7B7D, 1, TYPED, KIND_ERROR, 33'd0);         // empty braces
      add_row(3, 128'h7B2B7D, 1, TYPED, KIND_ERROR, 33'd0);       // plus, no digits
      add_row(4, 128'h7B20357D, 1, TYPED, KIND_ERROR, 33'd0);     // space inside
      add_row(4, 128'h7B2D357D, 1, TYPED, KIND_ERROR, 33'd0);     // sign inside
      add_row(4, 128'h22C3A922, 0, PREDICT, KIND_ERROR, 33'd0);
      add_row(5, 128'h22E282AC22, 1, PREDICT, KIND_ERROR, 33'd0);
      add_row(6, 128'h22F09F988022, 0, PREDICT, KIND_ERROR, 33'd0);
      add_row(4, 128'h22DFBF22, 0, PREDICT, KIND_ERROR, 33'd0);
      add_row(6, 128'h22F7BFBFBF22, 0, PREDICT, KIND_ERROR, 33'd0);
      add_row(3, 128'h22F822, 0, TYPED, KIND_ERROR, 33'd0);       // bad lead byte
      add_row(3, 128'h228022, 0, TYPED, KIND_ERROR, 33'd0);       // stray continuation
      add_row(4, 128'h22E28222, 0, TYPED, KIND_ERROR, 33'd0);     // sequence cut short
      add_row(3, 128'h220022, 0, TYPED, KIND_ERROR, 33'd0);       // NUL in quotes
      add_row(6, 128'h225C225C5C22, 0, PREDICT, KIND_ERROR, 33'd0);
      add_row(4, 128'h225C6E22, 0, TYPED, KIND_ERROR, 33'd0);     // bad escape
      add_row(1, 128'h22, 0, TYPED, KIND_ERROR, 33'd0);
      add_row(1, 128'hFF, 1, TYPED, KIND_ERROR, 33'd0);
      add_row(1, 128'h00, 0, TYPED, KIND_ERROR, 33'd0);
      for (int r = 0; r < token_rows.size(); r++) begin
         row = token_rows[r];
         tok_bytes.delete();
         for (int i = 0; i < row.n; i++) tok_bytes.push_back(row.bytes[8*(row.n-1-i) +: 8]);
         send_token(row.eol, row.typed, row.res);
      end

      // Random phases: limits and idling change from phase to phase
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: set_limits(16'd1, 16'd2, '0, 1'b0);
            1: set_limits(16'hFFFF, 16'hFFFF, VALUE_MAX, 1'b0);
            2: set_limits(16'd8, 16'd10, 33'd1000, 1'b1);
            default: begin
               case ($urandom_range(0, 2))
                  0:       lit = 33'($urandom_range(0, 9999));
                  1:       lit = {1'b0, 32'($urandom())};
                  default: lit = {1'b1, 32'($urandom())};
               endcase
               set_limits(16'($urandom_range(1, 16)), 16'($urandom_range(2, 20)), lit, 1'b0);
            end
         endcase
         case (p % 4)
            0: begin snd_pct = 0;  rcv_pct = 0;  end
            1: begin snd_pct = 49; rcv_pct = 0;  end
            2: begin snd_pct = 0;  rcv_pct = 49; end
            default: begin snd_pct = 38; rcv_pct = 38; end
         endcase
         phase_bytes = 0;
         while (phase_bytes < PHASE_BYTES) begin
            build_random_token(eol);
            phase_bytes += tok_bytes.size();
            send_token(eol, PREDICT, '0);
         end
      end

      wait_idle();
      if (errors == 0 && results_due.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
